// File: hdl/ljp_pkg.sv
// Shared types and constants for the Lennard-Jones potential unit.
package ljp_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CFG_MODE         = 2'd0;
   localparam logic [1:0] CFG_WELL_DEPTH   = 2'd1;
   localparam logic [1:0] CFG_MIN_DISTANCE = 2'd2;

   // Mode codes.
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_TRUNC = 2'd1;
   localparam logic [1:0] MODE_REP   = 2'd2;

   localparam logic [1:0]  MODE_RESET         = 2'd0;
   localparam logic [31:0] WELL_DEPTH_RESET   = 32'd65536;
   localparam logic [31:0] MIN_DISTANCE_RESET = 32'd16777216;

   // Widths of the datapath.
   localparam int CHUNK_W   = 32;
   localparam int QUO_W     = 37;
   localparam int DIV_STEPS = 37;
   localparam int MUL_A_CHUNKS = 2;
   localparam int MUL_B_CHUNKS = 2;
   localparam int MUL_SIDE_W   = 3;

   // Cutoff factor 2.2272467953508484 in Q2.30, and the energy shifts in Q.32.
   localparam logic [63:0] CUT_Q30     = 64'd2391488037;
   localparam logic [32:0] SHIFT_TRUNC = 33'd70080514;
   localparam logic [32:0] SHIFT_REP   = 33'h1_0000_0000;

   localparam logic [55:0] E_MAX = 56'h7F_FFFF_FFFF_FFFF;
   localparam logic [55:0] E_NEG = 56'h80_0000_0000_0000;

   typedef struct packed {
      logic zero;  // distance was zero
      logic kill;  // beyond cutoff or zero well depth
      logic huge;  // x too large, result saturates
   } ljp_flags_type;

endpackage

// File: hdl/ljp_req_if.sv
// Request channel carrying one pair distance per transfer.
interface ljp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] distance;

   modport source (output valid, output distance, input ready);
   modport sink (input valid, input distance, output ready);
endinterface

// File: hdl/ljp_rsp_if.sv
// Response channel carrying one energy result per transfer.
interface ljp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [55:0] energy;
   logic               saturated;

   modport source (output valid, output energy, output saturated, input ready);
   modport sink (input valid, input energy, input saturated, output ready);
endinterface

// File: hdl/ljp_mul.sv
// Two-stage pipelined multiplier built from 32 by 32 partial products.
module ljp_mul #(
   parameter int A_CHUNKS = ljp_pkg::MUL_A_CHUNKS,
   parameter int B_CHUNKS = ljp_pkg::MUL_B_CHUNKS,
   parameter int SIDE_W   = ljp_pkg::MUL_SIDE_W
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          enable,
   input  logic                                          valid_in,
   input  logic [A_CHUNKS*ljp_pkg::CHUNK_W-1:0]          a,
   input  logic [B_CHUNKS*ljp_pkg::CHUNK_W-1:0]          b,
   input  logic [SIDE_W-1:0]                             side_in,
   output logic                                          valid_out,
   output logic [SIDE_W-1:0]                             side_out,
   output logic [(A_CHUNKS+B_CHUNKS)*ljp_pkg::CHUNK_W-1:0] p
);
   localparam int CW = ljp_pkg::CHUNK_W;
   localparam int NP = A_CHUNKS * B_CHUNKS;
   localparam int PW = (A_CHUNKS + B_CHUNKS) * CW;

   logic [2*CW-1:0] pp_ff [0:NP-1];
   logic [2*CW-1:0] pp_in [0:NP-1];
   logic            valid1_ff, valid2_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff;
   logic [PW-1:0]   p_ff, p_in;

   always_comb begin
      for (int i = 0; i < A_CHUNKS; i++) begin
         for (int j = 0; j < B_CHUNKS; j++) begin
            pp_in[i*B_CHUNKS+j] = (2*CW)'(a[i*CW +: CW]) * (2*CW)'(b[j*CW +: CW]);
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < A_CHUNKS; i++) begin
         for (int j = 0; j < B_CHUNKS; j++) begin
            p_in = p_in + (PW'(pp_ff[i*B_CHUNKS+j]) << (CW * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= valid_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < NP; k++) begin
            pp_ff[k] <= pp_in[k];
         end
         side1_ff <= side_in;
         side2_ff <= side1_ff;
         p_ff     <= p_in;
      end
   end

   assign valid_out = valid2_ff;
   assign side_out  = side2_ff;
   assign p         = p_ff;
endmodule

// File: hdl/lennard_jones_potential_unit.sv
// Lennard-Jones 12-6 energy, pipelined from request transfer to response.
// Throughput is one distance per cycle; the 37-stage restoring divider for r0/r
// and the five two-stage partial-product multipliers set the latency.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-high reset clears all valid bits and loads the register
// defaults: mode 0, well depth 1.0, minimum distance 1.0.
module lennard_jones_potential_unit (
   input  logic        clock,
   input  logic        reset,
   ljp_req_if.sink     req_chan,
   ljp_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   localparam int NS = ljp_pkg::DIV_STEPS;
   localparam int QW = ljp_pkg::QUO_W;

   logic [1:0]  mode_ff;
   logic [31:0] well_depth_ff;
   logic [31:0] min_distance_ff;
   logic [63:0] cut_ff;

   logic enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= ljp_pkg::MODE_RESET;
         well_depth_ff   <= ljp_pkg::WELL_DEPTH_RESET;
         min_distance_ff <= ljp_pkg::MIN_DISTANCE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ljp_pkg::CFG_MODE:         mode_ff         <= csr_write_data[1:0];
            ljp_pkg::CFG_WELL_DEPTH:   well_depth_ff   <= csr_write_data;
            ljp_pkg::CFG_MIN_DISTANCE: min_distance_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The cutoff product only follows the configuration, so it is kept registered.
   always_ff @(posedge clock) begin
      cut_ff <= 64'(min_distance_ff) * ljp_pkg::CUT_Q30;
   end

   // ---------------- Divider: q = floor(r0 * 2^32 / r) ----------------
   logic          div_valid_ff [0:NS];
   logic [31:0]   div_rem_ff   [0:NS];
   logic [QW-1:0] div_quo_ff   [0:NS];
   logic [31:0]   div_r_ff     [0:NS];
   logic          div_zero_ff  [0:NS];
   logic          div_big_ff   [0:NS];
   logic [31:0]   div_rem_in   [0:NS];
   logic [QW-1:0] div_quo_in   [0:NS];

   // Quotients of 2^37 or more always give a huge x, so only 37 bits are formed.
   always_comb begin
      div_rem_in[0] = {5'd0, min_distance_ff[31:5]};
      div_quo_in[0] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (enable) begin
         div_valid_ff[0] <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_rem_ff[0]  <= div_rem_in[0];
         div_quo_ff[0]  <= div_quo_in[0];
         div_r_ff[0]    <= req_chan.distance;
         div_zero_ff[0] <= (req_chan.distance == 32'd0);
         div_big_ff[0]  <= ({5'd0, min_distance_ff} >= {req_chan.distance, 5'd0});
      end
   end

   genvar k;
   generate
      for (k = 1; k <= NS; k++) begin : g_div
         localparam int NB = NS - k;
         logic        nbit;
         logic [32:0] trial;
         logic [32:0] diff;
         logic        ge;

         if (NB >= 32) begin : g_hi
            assign nbit = min_distance_ff[NB-32];
         end else begin : g_lo
            assign nbit = 1'b0;
         end

         always_comb begin
            trial = {div_rem_ff[k-1], nbit};
            diff  = trial - {1'b0, div_r_ff[k-1]};
            ge    = (trial >= {1'b0, div_r_ff[k-1]});
            div_rem_in[k] = ge ? diff[31:0] : trial[31:0];
            div_quo_in[k] = {div_quo_ff[k-1][QW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               div_valid_ff[k] <= 1'b0;
            end else if (enable) begin
               div_valid_ff[k] <= div_valid_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               div_rem_ff[k]  <= div_rem_in[k];
               div_quo_ff[k]  <= div_quo_in[k];
               div_r_ff[k]    <= div_r_ff[k-1];
               div_zero_ff[k] <= div_zero_ff[k-1];
               div_big_ff[k]  <= div_big_ff[k-1];
            end
         end
      end
   endgenerate

   // ---------------- Special cases after the divider ----------------
   ljp_pkg::ljp_flags_type flags0;
   logic [31:0] r_end;
   logic        cut_trunc, cut_rep;

   assign r_end     = div_r_ff[NS];
   assign cut_trunc = (mode_ff == ljp_pkg::MODE_TRUNC) && ({2'd0, r_end, 30'd0} > cut_ff);
   assign cut_rep   = (mode_ff == ljp_pkg::MODE_REP) && (r_end > min_distance_ff);

   always_comb begin
      flags0.zero = div_zero_ff[NS];
      flags0.kill = cut_trunc || cut_rep || (well_depth_ff == 32'd0);
      flags0.huge = div_big_ff[NS];
   end

   // ---------------- q2 = q*q / 2^32 ----------------
   logic          m1_valid;
   logic [39:0]   m1_side;
   logic [127:0]  m1_p;
   logic [QW-1:0] q_d;
   logic [41:0]   q2;
   ljp_pkg::ljp_flags_type flags1;

   ljp_mul #(.A_CHUNKS(2), .B_CHUNKS(2), .SIDE_W(40)) u_mul_q2 (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_in(div_valid_ff[NS]),
      .a({27'd0, div_quo_ff[NS]}), .b({27'd0, div_quo_ff[NS]}),
      .side_in({flags0, div_quo_ff[NS]}),
      .valid_out(m1_valid), .side_out(m1_side), .p(m1_p)
   );

   assign q2     = m1_p[73:32];
   assign q_d    = m1_side[QW-1:0];
   assign flags1 = m1_side[39:37];

   // ---------------- q3 = q2*q / 2^32 ----------------
   logic         m2_valid;
   logic [2:0]   m2_side;
   logic [127:0] m2_p;
   logic [46:0]  q3;

   ljp_mul #(.A_CHUNKS(2), .B_CHUNKS(2), .SIDE_W(3)) u_mul_q3 (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_in(m1_valid),
      .a({22'd0, q2}), .b({27'd0, q_d}),
      .side_in(flags1),
      .valid_out(m2_valid), .side_out(m2_side), .p(m2_p)
   );

   assign q3 = m2_p[78:32];

   // ---------------- x = q3*q3 / 2^32 ----------------
   logic         m3_valid;
   logic [2:0]   m3_side;
   logic [127:0] m3_p;
   logic [63:0]  x_full;
   ljp_pkg::ljp_flags_type flags2, flags3;

   ljp_mul #(.A_CHUNKS(2), .B_CHUNKS(2), .SIDE_W(3)) u_mul_x (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_in(m2_valid),
      .a({17'd0, q3}), .b({17'd0, q3}),
      .side_in(m2_side),
      .valid_out(m3_valid), .side_out(m3_side), .p(m3_p)
   );

   assign x_full = m3_p[95:32];
   assign flags2 = m3_side;

   always_comb begin
      flags3      = flags2;
      flags3.huge = flags2.huge || (x_full[63:56] != 8'd0);
   end

   // ---------------- x*x ----------------
   logic         m4_valid;
   logic [58:0]  m4_side;
   logic [127:0] m4_p;
   logic [55:0]  x_d;
   ljp_pkg::ljp_flags_type flags4;

   ljp_mul #(.A_CHUNKS(2), .B_CHUNKS(2), .SIDE_W(59)) u_mul_xx (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_in(m3_valid),
      .a({8'd0, x_full[55:0]}), .b({8'd0, x_full[55:0]}),
      .side_in({flags3, x_full[55:0]}),
      .valid_out(m4_valid), .side_out(m4_side), .p(m4_p)
   );

   assign x_d    = m4_side[55:0];
   assign flags4 = m4_side[58:56];

   // ---------------- f = x*x/2^32 + S - 2x, split into sign and magnitude ----------
   logic [32:0] shift_sel;
   logic [80:0] f_pos, f_twox;
   logic        f_ge;
   logic        f_valid_ff;
   logic [80:0] f_mag_ff, f_mag_in;
   logic        f_neg_ff;
   logic        f_bigmag_ff;
   ljp_pkg::ljp_flags_type f_flags_ff;

   always_comb begin
      case (mode_ff)
         ljp_pkg::MODE_TRUNC: shift_sel = ljp_pkg::SHIFT_TRUNC;
         ljp_pkg::MODE_REP:   shift_sel = ljp_pkg::SHIFT_REP;
         default:             shift_sel = 33'd0;
      endcase
      f_pos    = {1'b0, m4_p[111:32]} + {48'd0, shift_sel};
      f_twox   = {24'd0, x_d, 1'b0};
      f_ge     = (f_pos >= f_twox);
      f_mag_in = f_ge ? (f_pos - f_twox) : (f_twox - f_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (enable) begin
         f_valid_ff <= m4_valid;
      end
   end

   // A magnitude of 2^79 or more saturates for any nonzero well depth.
   always_ff @(posedge clock) begin
      if (enable) begin
         f_mag_ff    <= f_mag_in;
         f_neg_ff    <= !f_ge;
         f_bigmag_ff <= (f_mag_in[80:79] != 2'd0);
         f_flags_ff  <= flags4;
      end
   end

   // ---------------- |f| * u0 ----------------
   logic         m5_valid;
   logic [4:0]   m5_side;
   logic [127:0] m5_p;
   logic [86:0]  e_mag;
   logic         e_neg, e_bigmag;
   ljp_pkg::ljp_flags_type flags5;

   ljp_mul #(.A_CHUNKS(3), .B_CHUNKS(1), .SIDE_W(5)) u_mul_energy (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_in(f_valid_ff),
      .a({17'd0, f_mag_ff[78:0]}), .b(well_depth_ff),
      .side_in({f_flags_ff, f_neg_ff, f_bigmag_ff}),
      .valid_out(m5_valid), .side_out(m5_side), .p(m5_p)
   );

   assign e_mag    = m5_p[110:24];
   assign e_bigmag = m5_side[0];
   assign e_neg    = m5_side[1];
   assign flags5   = m5_side[4:2];

   // ---------------- Saturation and output register ----------------
   logic        out_valid_ff;
   logic [55:0] energy_ff, energy_in;
   logic        sat_ff, sat_in;

   always_comb begin
      if (flags5.zero || (!flags5.kill && flags5.huge)) begin
         energy_in = ljp_pkg::E_MAX;
         sat_in    = 1'b1;
      end else if (flags5.kill) begin
         energy_in = 56'd0;
         sat_in    = 1'b0;
      end else if (!e_neg) begin
         if (e_bigmag || (e_mag > {31'd0, ljp_pkg::E_MAX})) begin
            energy_in = ljp_pkg::E_MAX;
            sat_in    = 1'b1;
         end else begin
            energy_in = e_mag[55:0];
            sat_in    = 1'b0;
         end
      end else begin
         if (e_mag > {31'd0, ljp_pkg::E_NEG}) begin
            energy_in = ljp_pkg::E_NEG;
            sat_in    = 1'b1;
         end else begin
            energy_in = 56'd0 - e_mag[55:0];
            sat_in    = 1'b0;
         end
      end
   end

   // The whole pipeline advances whenever the output register can take a result.
   assign enable = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= m5_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         energy_ff <= energy_in;
         sat_ff    <= sat_in;
      end
   end

   assign req_chan.ready     = enable;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.energy    = energy_ff;
   assign rsp_chan.saturated = sat_ff;
endmodule

// File: hdl/ljp_checker.sv
// Port-level assertions for the Lennard-Jones potential unit, with its bind.
module ljp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [55:0] rsp_energy,
   input logic        rsp_saturated
);
   // A result waiting for its transfer stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled result keeps its energy.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_energy))
      else $error("response energy changed while stalled");

   // Requests are taken exactly when the output register can move.
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response flow");

   // A saturated result sits at one end of the energy range.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_energy == ljp_pkg::E_MAX) || (rsp_energy == ljp_pkg::E_NEG))
      else $error("saturated energy not at a range end");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind lennard_jones_potential_unit ljp_checker u_ljp_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_energy(rsp_chan.energy),
   .rsp_saturated(rsp_chan.saturated)
);
